### rtl/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: opcodes, status codes,
// controller states and the control group that drives the cell row.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Width of every reported word on the result channel
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

    typedef logic signed [WORD_W-1:0] t_word;

    // Operation codes carried with each input transfer
    typedef enum logic [2:0] {
        OP_NOP        = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_REAR  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_REAR   = 3'd4,
        OP_CLEAR      = 3'd5
    } t_opcode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_BUILD,
        S_SEND
    } t_state;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic push_front;   // shift toward the rear, cell 0 takes the new word
        logic pop_front;    // shift toward the front
        logic push_rear;    // cell at index count takes the new word
    } t_cell_ctrl;

endpackage : deq_pkg
`default_nettype wire

### rtl/deq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_in_if / deq_out_if
// Valid/ready channels of the double-ended queue: operation requests in,
// one result per request out.
// ----------------------------------------------------------------------------
interface deq_in_if;
    logic                 valid;
    logic                 ready;
    logic [2:0]           opcode;
    logic signed [31:0]   push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface : deq_in_if

interface deq_out_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic signed [31:0]   popped_value;
    logic signed [31:0]   front_value;
    logic signed [31:0]   rear_value;
    logic [4:0]           element_count;
    logic                 is_empty;

    modport source (output valid, output status, output popped_value,
                    output front_value, output rear_value, output element_count,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input front_value, input rear_value, input element_count,
                    input is_empty, output ready);
endinterface : deq_out_if
`default_nettype wire

### rtl/deq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row. Holds one word, shifts toward either
// neighbor on front operations and loads the new word on a rear push when
// it is the first free position.
// ----------------------------------------------------------------------------
module deq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
) (
    input  wire                       i_clk,
    input  deq_pkg::t_cell_ctrl       i_ctrl,
    input  wire [DATA_WIDTH-1:0]      i_push,
    input  wire [DATA_WIDTH-1:0]      i_left,
    input  wire [DATA_WIDTH-1:0]      i_right,
    input  wire [CNT_W-1:0]           i_count,
    output logic [DATA_WIDTH-1:0]     o_data,
    output logic                      o_rear_hit
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Next word: front ops move the whole row, rear push hits one cell
    always_comb begin
        n_data = r_data;
        if (i_ctrl.push_front) begin
            n_data = i_left;
        end else if (i_ctrl.pop_front) begin
            n_data = i_right;
        end else if (i_ctrl.push_rear && (i_count == CNT_W'(IDX))) begin
            n_data = i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    // This cell holds the rear word when count is one past its index
    assign o_rear_hit = (i_count == CNT_W'(IDX + 1));

endmodule : deq_cell
`default_nettype wire

### rtl/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words built as a row of shifting storage cells.
// ----------------------------------------------------------------------------
// The front word always sits in cell 0 and the rear word in cell count-1:
// front pushes and pops shift the whole row by one cell, rear pushes write
// the first free cell, rear pops only drop the count. For each request
// the transfer edge updates the row and latches status and popped word,
// the BUILD state then registers the front and rear words of the new
// contents, and the result is held in SEND until the output transfer;
// the next request is taken after that transfer. Pushes to a full queue
// report overflow, pops from an empty queue report underflow, and both
// leave the contents untouched. Clear empties the queue. Words are stored
// in DATA_WIDTH bits and reported sign-extended (or truncated) to 32 bits;
// cell contents are not reset.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    deq_in_if.sink   i_in,
    deq_out_if.source o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Controller registers
    deq_pkg::t_state        r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    deq_pkg::t_status       r_status, n_status;
    deq_pkg::t_word         r_popped, n_popped;
    deq_pkg::t_word         r_front, r_rear;
    deq_pkg::t_cell_ctrl    w_ctrl;

    // Cell row
    logic [DATA_WIDTH-1:0]  w_data [DEPTH];
    logic [DEPTH-1:0]       w_hit;
    logic [DATA_WIDTH-1:0]  w_rear;
    logic [DATA_WIDTH-1:0]  w_push;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_accept;

    assign w_push   = DATA_WIDTH'(i_in.push_value);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_accept = i_in.valid && i_in.ready;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;

            if (gi == 0) begin : g_first
                assign w_left = w_push;
            end else begin : g_mid_l
                assign w_left = w_data[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_data[gi+1];
            end

            deq_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CNT_W      (CNT_W),
                .IDX        (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_push     (w_push),
                .i_left     (w_left),
                .i_right    (w_right),
                .i_count    (r_count),
                .o_data     (w_data[gi]),
                .o_rear_hit (w_hit[gi])
            );
        end
    endgenerate

    // Rear word select: one-hot hit from the cells, zero when empty
    always_comb begin
        w_rear = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rear = w_rear | (w_data[i] & {DATA_WIDTH{w_hit[i]}});
        end
    end

    // State register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
        if (r_state == deq_pkg::S_BUILD) begin
            r_front <= w_empty ? '0 : deq_pkg::t_word'(signed'(w_data[0]));
            r_rear  <= deq_pkg::t_word'(signed'(w_rear));
        end
    end

    // Next state, operation decode and cell commands
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = deq_pkg::ST_OK;
        n_popped = '0;
        w_ctrl   = '0;
        case (r_state)
            deq_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = deq_pkg::S_BUILD;
                    case (deq_pkg::t_opcode'(i_in.opcode))
                        deq_pkg::OP_PUSH_FRONT: begin
                            if (w_full) begin
                                n_status = deq_pkg::ST_OVERFLOW;
                            end else begin
                                w_ctrl.push_front = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        deq_pkg::OP_PUSH_REAR: begin
                            if (w_full) begin
                                n_status = deq_pkg::ST_OVERFLOW;
                            end else begin
                                w_ctrl.push_rear = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        deq_pkg::OP_POP_FRONT: begin
                            if (w_empty) begin
                                n_status = deq_pkg::ST_UNDERFLOW;
                            end else begin
                                w_ctrl.pop_front = 1'b1;
                                n_popped = deq_pkg::t_word'(signed'(w_data[0]));
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        deq_pkg::OP_POP_REAR: begin
                            if (w_empty) begin
                                n_status = deq_pkg::ST_UNDERFLOW;
                            end else begin
                                n_popped = deq_pkg::t_word'(signed'(w_rear));
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        deq_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            // nop and unused codes leave the queue alone
                        end
                    endcase
                end
            end
            deq_pkg::S_BUILD: begin
                n_state = deq_pkg::S_SEND;
            end
            deq_pkg::S_SEND: begin
                if (o_out.ready) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    // Channel outputs
    assign i_in.ready          = (r_state == deq_pkg::S_IDLE);
    assign o_out.valid         = (r_state == deq_pkg::S_SEND);
    assign o_out.status        = r_status;
    assign o_out.popped_value  = r_popped;
    assign o_out.front_value   = r_front;
    assign o_out.rear_value    = r_rear;
    assign o_out.element_count = deq_pkg::COUNT_W'(r_count);
    assign o_out.is_empty      = w_empty;

endmodule : double_ended_queue
`default_nettype wire

### tb/sv/double_ended_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the bounded double-ended queue. Every accepted
// request runs through a bench-side deque that predicts the complete result
// record: status, popped word, front and rear words, count and empty flag.
// Directed requests cover the corner cases. Random sweeps then push the
// queue to full and back to empty, and both channels idle in random bursts.
// A long result stall and a sender pause are also exercised.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int EXT_SHIFT  = deq_pkg::WORD_W - DATA_WIDTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;

    // Opcodes outside the enum; the block treats them as no-ops
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        logic [1:0]      status;
        deq_pkg::t_word  popped;
        deq_pkg::t_word  front;
        deq_pkg::t_word  rear;
        logic [4:0]      count;
        logic            empty;
    } t_deq_result;

    logic clk;
    logic rst_n;

    deq_in_if  in_if ();
    deq_out_if out_if ();

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Bench-side deque and the results it still owes
    deq_pkg::t_word  ring_words [DEPTH];
    int              ring_head;
    int              ring_fill;
    t_deq_result     owed_results [$];

    // Run control and statistics
    bit  idle_on;
    int  rx_hold;
    int  rx_burst;
    int  cycle_cnt;
    int  fail_cnt;
    int  op_seen [8];
    int  overflow_seen;
    int  underflow_seen;
    int  full_seen;

    // Clock, 4 ns period
    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    // Hard stop if the run hangs
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, owed_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Apply one request to the bench deque and return the record it yields
    function automatic t_deq_result deq_apply(logic [2:0] op, deq_pkg::t_word val);
        t_deq_result     r;
        deq_pkg::t_word  kept;
        int              pos;
        kept = val <<< EXT_SHIFT;
        kept = kept >>> EXT_SHIFT;
        r.status = deq_pkg::ST_OK;
        r.popped = '0;
        case (op)
            deq_pkg::OP_PUSH_FRONT: begin
                if (ring_fill >= DEPTH) begin
                    r.status = deq_pkg::ST_OVERFLOW;
                end else begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_words[ring_head] = kept;
                    ring_fill++;
                end
            end
            deq_pkg::OP_PUSH_REAR: begin
                if (ring_fill >= DEPTH) begin
                    r.status = deq_pkg::ST_OVERFLOW;
                end else begin
                    ring_words[(ring_head + ring_fill) % DEPTH] = kept;
                    ring_fill++;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (ring_fill == 0) begin
                    r.status = deq_pkg::ST_UNDERFLOW;
                end else begin
                    r.popped = ring_words[ring_head];
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_fill--;
                end
            end
            deq_pkg::OP_POP_REAR: begin
                if (ring_fill == 0) begin
                    r.status = deq_pkg::ST_UNDERFLOW;
                end else begin
                    pos = (ring_head + ring_fill - 1) % DEPTH;
                    r.popped = ring_words[pos];
                    ring_fill--;
                end
            end
            deq_pkg::OP_CLEAR: begin
                ring_head = 0;
                ring_fill = 0;
            end
            default: ;
        endcase
        if (ring_fill == 0) begin
            r.front = '0;
            r.rear  = '0;
            r.empty = 1'b1;
        end else begin
            r.front = ring_words[ring_head];
            r.rear  = ring_words[(ring_head + ring_fill - 1) % DEPTH];
            r.empty = 1'b0;
        end
        r.count = ring_fill[4:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        fail_cnt++;
        if (fail_cnt <= PRINT_LIMIT)
            $display("[%0t] mismatch %s: got %0d (0x%0h) expected %0d (0x%0h)",
                     $realtime, what, got, got, want, want);
    endtask

    // Offer one request; returns on the negedge after its transfer
    task automatic send_request(logic [2:0] op, deq_pkg::t_word val);
        t_deq_result r;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.opcode     <= op;
        in_if.push_value <= val;
        do @(posedge clk); while (!in_if.ready);
        r = deq_apply(op, val);
        owed_results.push_back(r);
        op_seen[op]++;
        if (r.status == deq_pkg::ST_OVERFLOW) overflow_seen++;
        if (r.status == deq_pkg::ST_UNDERFLOW) underflow_seen++;
        if (ring_fill == DEPTH) full_seen++;
        @(negedge clk);
    endtask

    // Corner words show up often; the rest is uniform
    function automatic deq_pkg::t_word pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Random requests with a given share of pushes among pushes and pops
    task automatic random_sweep(int n, int push_pct, int clear_pct);
        int          k;
        int          roll;
        logic [2:0]  op;
        for (k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < clear_pct)
                op = deq_pkg::OP_CLEAR;
            else if (roll < clear_pct + 3)
                case ($urandom_range(0, 2))
                    0:       op = deq_pkg::OP_NOP;
                    1:       op = OP_SPARE_6;
                    default: op = OP_SPARE_7;
                endcase
            else if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_REAR;
            else
                op = $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_REAR;
            send_request(op, pick_word());
        end
    endtask

    // Lower valid and let every owed result come back
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // Result channel: ready with random stall bursts and an optional long hold
    always @(negedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            out_if.ready <= 1'b0;
            rx_hold--;
        end else if (rx_burst > 0) begin
            out_if.ready <= 1'b0;
            rx_burst--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            out_if.ready <= 1'b0;
            rx_burst = $urandom_range(1, 18) - 1;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge clk) begin
        t_deq_result want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (owed_results.size() == 0) begin
                report_mismatch("result with nothing pending", out_if.status, 0);
            end else begin
                want = owed_results.pop_front();
                if (out_if.status !== want.status)
                    report_mismatch("status", out_if.status, want.status);
                if (out_if.popped_value !== want.popped)
                    report_mismatch("popped_value", out_if.popped_value, want.popped);
                if (out_if.front_value !== want.front)
                    report_mismatch("front_value", out_if.front_value, want.front);
                if (out_if.rear_value !== want.rear)
                    report_mismatch("rear_value", out_if.rear_value, want.rear);
                if (out_if.element_count !== want.count)
                    report_mismatch("element_count", out_if.element_count, want.count);
                if (out_if.is_empty !== want.empty)
                    report_mismatch("is_empty", out_if.is_empty, want.empty);
            end
        end
    end

    // Corner cases on an empty and a lightly filled queue
    task automatic test_directed();
        send_request(deq_pkg::OP_NOP, '0);
        send_request(deq_pkg::OP_POP_FRONT, 32'sd11);
        send_request(deq_pkg::OP_POP_REAR, -32'sd11);
        send_request(deq_pkg::OP_CLEAR, '0);
        send_request(deq_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(deq_pkg::OP_PUSH_REAR, 32'sh8000_0000);
        send_request(deq_pkg::OP_PUSH_FRONT, '0);
        send_request(deq_pkg::OP_PUSH_REAR, -32'sd1);
        send_request(OP_SPARE_6, 32'sh5A5A_A5A5);
        send_request(OP_SPARE_7, 32'shA5A5_5A5A);
        send_request(deq_pkg::OP_POP_REAR, '0);
        send_request(deq_pkg::OP_POP_FRONT, '0);
        send_request(deq_pkg::OP_CLEAR, '0);
        send_request(deq_pkg::OP_PUSH_REAR, 32'sd1);
        send_request(deq_pkg::OP_POP_FRONT, '0);
        send_request(deq_pkg::OP_PUSH_FRONT, -32'sd2);
        send_request(deq_pkg::OP_POP_REAR, '0);
        send_request(deq_pkg::OP_POP_REAR, '0);
    endtask

    // Push-heavy: reach full from both ends and overflow it
    task automatic test_fill_overflow();
        random_sweep(160, 85, 0);
    endtask

    // Pop-heavy: drain from both ends and underflow it
    task automatic test_drain_underflow();
        random_sweep(160, 15, 0);
    endtask

    // Balanced traffic with occasional clears, swinging between full and empty
    task automatic test_random_mix();
        int k;
        for (k = 0; k < 10; k++) begin
            random_sweep(50, 80, 2);
            random_sweep(50, 20, 2);
        end
    endtask

    // Result side holds off for a long stretch; input must stall meanwhile
    task automatic test_result_stall();
        @(posedge clk);
        rx_hold = 300;
        @(negedge clk);
        random_sweep(40, 60, 0);
    endtask

    // Sender goes quiet until the queue has answered everything
    task automatic test_sender_pause();
        random_sweep(20, 70, 0);
        drain_results();
        random_sweep(20, 30, 0);
    endtask

    // No idling on either side: requests are offered back to back
    task automatic test_full_rate();
        int k;
        idle_on = 1'b0;
        for (k = 0; k < 4; k++) begin
            random_sweep(50, 85, 1);
            random_sweep(50, 15, 1);
        end
    endtask

    initial begin
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.opcode     = deq_pkg::OP_NOP;
        in_if.push_value = '0;
        out_if.ready     = 1'b0;
        idle_on   = 1'b1;
        rx_hold   = 0;
        rx_burst  = 0;
        cycle_cnt = 0;
        fail_cnt  = 0;
        overflow_seen  = 0;
        underflow_seen = 0;
        full_seen      = 0;
        foreach (op_seen[i]) op_seen[i] = 0;
        ring_head = 0;
        ring_fill = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_fill_overflow();
        test_drain_underflow();
        test_random_mix();
        test_result_stall();
        test_sender_pause();
        test_full_rate();

        drain_results();
        repeat (10) @(posedge clk);

        $display("ops nop/pf/pr/popf/popr/clr/spare: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
                 op_seen[5], op_seen[6] + op_seen[7]);
        $display("overflows %0d, underflows %0d, full %0d times, mismatches %0d",
                 overflow_seen, underflow_seen, full_seen, fail_cnt);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule : double_ended_queue_tb
